/* sv/tair_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tair_pkg
// Shared types and constants for the tensor axis index resolver.
// ----------------------------------------------------------------------------
package tair_pkg;

  localparam int DEF_INDEX_BITS = 32;
  localparam int SIZE_W         = 31;
  localparam int STRIDE_W       = 32;
  localparam int IDX_W          = 32;
  localparam int LEN_W          = 31;
  localparam int PROD_W         = 64;
  localparam int VAL_W          = 34;

  typedef enum logic [1:0] {
    KIND_INDEX   = 2'd0,
    KIND_SLICE   = 2'd1,
    KIND_NEWAXIS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_STEP = 2'd1,
    ST_BIG_STEP  = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [SIZE_W-1:0]          axis_size;
    logic signed [STRIDE_W-1:0] axis_stride;
    logic                       has_start;
    logic signed [IDX_W-1:0]    index_start;
    logic                       has_stop;
    logic signed [IDX_W-1:0]    index_stop;
    logic signed [IDX_W-1:0]    slice_step;
  } req_t;

  typedef struct packed {
    logic                     keeps_axis;
    logic [LEN_W-1:0]         out_length;
    logic signed [PROD_W-1:0] out_stride;
    logic signed [PROD_W-1:0] offset_delta;
    status_t                  status;
  } rsp_t;

  typedef struct packed {
    logic                     keeps;
    logic                     len_en;
    logic                     stride_en;
    logic                     delta_en;
    status_t                  status;
    logic signed [PROD_W-1:0] ostride;
    logic signed [PROD_W-1:0] delta;
  } meta_t;

  typedef struct packed {
    logic             valid;
    meta_t            meta;
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] num;
    logic [LEN_W-1:0] quo;
    logic [LEN_W:0]   dv;
  } cell_t;

endpackage

/* sv/tensor_axis_index_resolver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_axis_index_resolver
// Resolves one index component (integer, slice or new axis) against one axis.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one component and the axis size and stride; it is taken when
//   req_valid and req_ready are both high. rsp carries length, stride, offset
//   delta and status, and leaves when rsp_valid and rsp_ready are both high.
//   Each item gives exactly one result, in order.
// Throughput: one item per cycle while the skid stage below is not full.
// Pipeline: three front stages (wrap, clamp, span and products), one cell
//   per length bit of the slice-length division row (31 cells), and the
//   output register.
// Stall: while rsp is held the row keeps moving into a one-item skid stage;
//   once that stage is full, req_ready drops and the whole row holds.
// Reset: rst clears every valid bit; the row empties and req_ready is high
//   from the first cycle after reset.
// ----------------------------------------------------------------------------
module tensor_axis_index_resolver #(
  parameter int INDEX_BITS = tair_pkg::DEF_INDEX_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tair_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tair_pkg::rsp_t rsp
);

  localparam int LW = tair_pkg::LEN_W;

  tair_pkg::cell_t chain [LW+1];
  logic            en;

  assign req_ready = en;

  tair_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .req_valid(req_valid),
    .req      (req),
    .head     (chain[0])
  );

  for (genvar i = 0; i < LW; i++) begin : g_cell
    tair_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .prev(chain[i]),
      .next(chain[i+1])
    );
  end

  tair_out u_out (
    .clk      (clk),
    .rst      (rst),
    .tail     (chain[LW]),
    .en       (en),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

/* sv/tair_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tair_front
// Decode, wrap, clamp, span and stride products; feeds the divider row.
// ----------------------------------------------------------------------------
module tair_front #(
  parameter int INDEX_BITS = tair_pkg::DEF_INDEX_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           req_valid,
  input  tair_pkg::req_t req,
  output tair_pkg::cell_t head
);

  localparam int VW = tair_pkg::VAL_W;
  localparam int LW = tair_pkg::LEN_W;
  localparam int SW = tair_pkg::STRIDE_W;
  localparam int SH = 64 - INDEX_BITS;
  localparam logic signed [63:0]   STEP_MIN = -(64'sd1 <<< (INDEX_BITS - 1));
  localparam logic signed [VW-1:0] V_ZERO   = '0;
  localparam logic signed [VW-1:0] V_ONE    = VW'(1);
  localparam logic signed [VW-1:0] V_NEG1   = '1;
  localparam logic [LW:0]          DV_SAT   = {1'b1, {LW{1'b0}}};
  localparam logic [LW:0]          DV_ONE   = (LW + 1)'(1);

  function automatic logic signed [63:0] sx64(input logic [tair_pkg::IDX_W-1:0] f);
    logic [63:0] raw;
    raw = {{(64 - tair_pkg::IDX_W){1'b0}}, f};
    return $signed(raw << SH) >>> SH;
  endfunction

  function automatic logic signed [VW-1:0] clampv(input logic signed [VW-1:0] v,
                                                   input logic signed [VW-1:0] lo,
                                                   input logic signed [VW-1:0] hi);
    logic signed [VW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // first stage
  logic signed [63:0]   start64, stop64, step64;
  logic signed [VW-1:0] start_v, stop_v, step_v, size_v, size_m1_v;
  logic signed [VW-1:0] start_w, stop_w, step_abs, b_w, e_w;
  logic                 step_zero, step_pos, use_start;
  logic [LW:0]          dv_v;
  tair_pkg::status_t    status_v;

  logic                     s1_valid;
  logic [1:0]               s1_kind;
  tair_pkg::status_t        s1_status;
  logic                     s1_pos;
  logic signed [VW-1:0]     s1_size, s1_size_m1, s1_step, s1_b, s1_e;
  logic signed [SW-1:0]     s1_stride;
  logic [LW:0]              s1_dv;

  always_comb begin
    start64   = sx64(req.index_start);
    stop64    = sx64(req.index_stop);
    step64    = sx64(req.slice_step);
    start_v   = start64[VW-1:0];
    stop_v    = stop64[VW-1:0];
    step_v    = step64[VW-1:0];
    size_v    = $signed({{(VW - tair_pkg::SIZE_W){1'b0}}, req.axis_size});
    size_m1_v = size_v - V_ONE;
    step_zero = (step_v == V_ZERO);
    step_pos  = !step_v[VW-1] && !step_zero;
    step_abs  = step_v[VW-1] ? -step_v : step_v;
    dv_v      = (|step_abs[VW-1:LW]) ? DV_SAT : step_abs[LW:0];
    use_start = req.has_start || (req.req_type == tair_pkg::KIND_INDEX);
    start_w   = start_v[VW-1] ? start_v + size_v : start_v;
    stop_w    = stop_v[VW-1] ? stop_v + size_v : stop_v;
    b_w       = use_start ? start_w : (step_pos ? V_ZERO : size_m1_v);
    e_w       = req.has_stop ? stop_w : (step_pos ? size_v : V_NEG1);
    status_v  = tair_pkg::ST_OK;
    if (req.req_type == tair_pkg::KIND_SLICE) begin
      if (step_zero) status_v = tair_pkg::ST_ZERO_STEP;
      else if (step64 == STEP_MIN) status_v = tair_pkg::ST_BIG_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind    <= req.req_type;
      s1_status  <= status_v;
      s1_pos     <= step_pos;
      s1_size    <= size_v;
      s1_size_m1 <= size_m1_v;
      s1_step    <= step_v;
      s1_stride  <= req.axis_stride;
      s1_dv      <= dv_v;
      s1_b       <= b_w;
      s1_e       <= e_w;
    end
  end

  // second stage
  logic signed [VW-1:0] lo_v, hi_v, bc_v, ec_v;
  logic                 range_err;
  tair_pkg::status_t    status2_v;

  logic                 s2_valid;
  logic [1:0]           s2_kind;
  tair_pkg::status_t    s2_status;
  logic                 s2_pos;
  logic signed [VW-1:0] s2_step, s2_bc, s2_ec;
  logic signed [SW-1:0] s2_stride;
  logic [LW:0]          s2_dv;

  always_comb begin
    lo_v      = s1_pos ? V_ZERO : V_NEG1;
    hi_v      = s1_pos ? s1_size : s1_size_m1;
    bc_v      = (s1_kind == tair_pkg::KIND_INDEX) ? s1_b : clampv(s1_b, lo_v, hi_v);
    ec_v      = clampv(s1_e, lo_v, hi_v);
    range_err = s1_b[VW-1] || (s1_b >= s1_size);
    status2_v = ((s1_kind == tair_pkg::KIND_INDEX) && range_err) ?
                tair_pkg::ST_RANGE : s1_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind   <= s1_kind;
      s2_status <= status2_v;
      s2_pos    <= s1_pos;
      s2_step   <= s1_step;
      s2_stride <= s1_stride;
      s2_dv     <= s1_dv;
      s2_bc     <= bc_v;
      s2_ec     <= ec_v;
    end
  end

  // third stage: span, products, divider operands
  logic signed [VW-1:0]    span, span_m1;
  logic                    nonempty, ok, slice_ok, is_index, is_newaxis;
  logic signed [VW+SW-1:0] p_stride, p_delta;
  tair_pkg::cell_t         head_next;

  always_comb begin
    span       = s2_pos ? s2_ec - s2_bc : s2_bc - s2_ec;
    span_m1    = span - V_ONE;
    nonempty   = (span > V_ZERO);
    ok         = (s2_status == tair_pkg::ST_OK);
    is_index   = (s2_kind == tair_pkg::KIND_INDEX);
    is_newaxis = (s2_kind == tair_pkg::KIND_NEWAXIS);
    slice_ok   = (s2_kind == tair_pkg::KIND_SLICE) && ok;
    p_stride   = s2_step * s2_stride;
    p_delta    = s2_bc * s2_stride;

    head_next                = '0;
    head_next.valid          = s2_valid;
    head_next.meta.keeps     = slice_ok || is_newaxis;
    head_next.meta.len_en    = (slice_ok && nonempty) || is_newaxis;
    head_next.meta.stride_en = slice_ok;
    head_next.meta.delta_en  = (is_index && ok) || (slice_ok && nonempty);
    head_next.meta.status    = s2_status;
    head_next.meta.ostride   = p_stride[tair_pkg::PROD_W-1:0];
    head_next.meta.delta     = p_delta[tair_pkg::PROD_W-1:0];
    head_next.num            = is_newaxis ? '0 : span_m1[LW-1:0];
    head_next.dv             = is_newaxis ? DV_ONE : s2_dv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (en) begin
      head.valid <= head_next.valid;
    end
    if (en) begin
      head.meta <= head_next.meta;
      head.rem  <= head_next.rem;
      head.num  <= head_next.num;
      head.quo  <= head_next.quo;
      head.dv   <= head_next.dv;
    end
  end

endmodule

/* sv/tair_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tair_cell
// One restoring-division step: one quotient bit per cell, passed to the next.
// ----------------------------------------------------------------------------
module tair_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  tair_pkg::cell_t prev,
  output tair_pkg::cell_t next
);

  localparam int LW = tair_pkg::LEN_W;

  logic [LW:0] trial, diff;
  logic        fit;

  always_comb begin
    trial = {prev.rem, prev.num[LW-1]};
    fit   = (trial >= prev.dv);
    diff  = trial - prev.dv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
    if (en) begin
      next.meta <= prev.meta;
      next.rem  <= fit ? diff[LW-1:0] : trial[LW-1:0];
      next.num  <= {prev.num[LW-2:0], 1'b0};
      next.quo  <= {prev.quo[LW-2:0], fit};
      next.dv   <= prev.dv;
    end
  end

endmodule

/* sv/tair_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tair_out
// Final result assembly, output register and skid stage.
// ----------------------------------------------------------------------------
module tair_out (
  input  logic            clk,
  input  logic            rst,
  input  tair_pkg::cell_t tail,
  output logic            en,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output tair_pkg::rsp_t  rsp
);

  localparam int LW = tair_pkg::LEN_W;

  tair_pkg::rsp_t item, skid;
  logic           skid_valid, load;

  always_comb begin
    en                = !skid_valid;
    load              = tail.valid && en;
    item.keeps_axis   = tail.meta.keeps;
    item.out_length   = tail.meta.len_en ? tail.quo + LW'(1) : '0;
    item.out_stride   = tail.meta.stride_en ? tail.meta.ostride : '0;
    item.offset_delta = tail.meta.delta_en ? tail.meta.delta : '0;
    item.status       = tail.meta.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!rsp_valid || rsp_ready) begin
        rsp_valid  <= 1'b1;
        rsp        <= skid;
        skid_valid <= 1'b0;
      end
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid <= load;
      rsp       <= item;
    end else if (load) begin
      skid_valid <= 1'b1;
      skid       <= item;
    end
  end

endmodule

/* sv/tair_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tair_checker
// Port-level checks for the tensor axis index resolver.
// ----------------------------------------------------------------------------
module tair_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input tair_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp item changed or dropped while stalled");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> $past(rsp_valid && !rsp_ready))
    else $error("req_ready low without an output stall");

  a_drop_axis: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.keeps_axis |-> rsp.out_length == '0 && rsp.out_stride == '0)
    else $error("dropped axis with nonzero length or stride");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != tair_pkg::ST_OK
      |-> !rsp.keeps_axis && rsp.offset_delta == '0)
    else $error("error item with live fields");

  a_idle_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid high after reset");

endmodule

bind tensor_axis_index_resolver tair_checker u_tair_checker (
  .clk      (clk),
  .rst      (rst),
  .req_ready(req_ready),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

/* tb/tensor_axis_index_resolver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_axis_index_resolver_tb
// Self-checking bench for the tensor axis index resolver.
// ----------------------------------------------------------------------------
// A table of directed components covers the field extremes, every component
// kind, the step and range errors, empty and clamped slices, and the unused
// kind. A random stream of components then follows. Every result is checked
// in order against a local resolver function, or against a typed-in value
// where the table gives one. The pacing runs in three phases: a slow receiver,
// then a slow sender, then no idling. A long receiver hold-off in the last
// phase fills the pipeline and stalls the input.
// ----------------------------------------------------------------------------
module tensor_axis_index_resolver_tb;

  localparam int           IDX_BITS       = tair_pkg::DEF_INDEX_BITS;
  localparam logic [1:0]   KIND_UNUSED    = 2'd3;
  localparam logic [31:0]  IDX_MIN        = 32'h8000_0000;
  localparam logic [31:0]  IDX_MAX        = 32'h7fff_ffff;
  localparam logic [30:0]  SIZE_MAX       = 31'h7fff_ffff;
  localparam int           RANDOM_ITEMS   = 850;
  localparam int           HOLD_CYCLES    = 160;
  localparam int           DRAIN_CYCLES   = 40;
  localparam int           WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    tair_pkg::req_t stim;
    logic           pinned;
    tair_pkg::rsp_t want;
  } dir_row_t;

  logic           clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  tair_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  tair_pkg::rsp_t rsp;

  tair_pkg::rsp_t resolved_q[$];
  dir_row_t       dir_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase         = 0;
  int components_sent;
  int resolutions_checked;
  int mismatches;
  int input_stalls;
  int idle_cycles;
  int hold_left;
  bit hold_done;

  tensor_axis_index_resolver u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint idx_value(logic [31:0] v);
    longint x;
    x = longint'(v);
    return (x <<< (64 - IDX_BITS)) >>> (64 - IDX_BITS);
  endfunction

  function automatic tair_pkg::rsp_t resolve_component(tair_pkg::req_t r);
    tair_pkg::rsp_t res;
    longint         size, stride, start, stop, step, sel, b, e, count;
    res    = '0;
    size   = longint'(r.axis_size);
    stride = longint'($signed(r.axis_stride));
    start  = idx_value(r.index_start);
    stop   = idx_value(r.index_stop);
    step   = idx_value(r.slice_step);
    count  = 0;
    if (r.req_type == tair_pkg::KIND_INDEX) begin
      sel = start;
      if (sel < 0) sel = sel + size;
      if (sel < 0 || sel >= size) res.status = tair_pkg::ST_RANGE;
      else res.offset_delta = sel * stride;
    end else if (r.req_type == tair_pkg::KIND_SLICE) begin
      if (step == 0) begin
        res.status = tair_pkg::ST_ZERO_STEP;
      end else if (step == -(64'sd1 <<< (IDX_BITS - 1))) begin
        res.status = tair_pkg::ST_BIG_STEP;
      end else begin
        if (step > 0) begin
          b = r.has_start ? start : 0;
          e = r.has_stop ? stop : size;
        end else begin
          b = r.has_start ? start : size - 1;
          e = r.has_stop ? stop : -1;
        end
        if (r.has_start && b < 0) b = b + size;
        if (r.has_stop && e < 0) e = e + size;
        if (step > 0) begin
          b = (b < 0) ? 0 : (b > size) ? size : b;
          e = (e < 0) ? 0 : (e > size) ? size : e;
          if (e > b) count = 1 + (e - b - 1) / step;
        end else begin
          b = (b < -1) ? -1 : (b > size - 1) ? size - 1 : b;
          e = (e < -1) ? -1 : (e > size - 1) ? size - 1 : e;
          if (b > e) count = 1 + (b - e - 1) / (-step);
        end
        res.keeps_axis = 1'b1;
        res.out_length = count[tair_pkg::LEN_W-1:0];
        res.out_stride = stride * step;
        if (count != 0) res.offset_delta = b * stride;
      end
    end else if (r.req_type == tair_pkg::KIND_NEWAXIS) begin
      res.keeps_axis = 1'b1;
      res.out_length = 1;
    end
    return res;
  endfunction

  function automatic tair_pkg::req_t mk_req(logic [1:0] k, logic [30:0] size,
                                            logic [31:0] stride, logic hs,
                                            logic [31:0] start, logic ht,
                                            logic [31:0] stop, logic [31:0] step);
    tair_pkg::req_t r;
    r.req_type    = k;
    r.axis_size   = size;
    r.axis_stride = stride;
    r.has_start   = hs;
    r.index_start = start;
    r.has_stop    = ht;
    r.index_stop  = stop;
    r.slice_step  = step;
    return r;
  endfunction

  function automatic tair_pkg::rsp_t pin_rsp(logic keeps, logic [30:0] len,
                                             tair_pkg::status_t st);
    tair_pkg::rsp_t res;
    res            = '0;
    res.keeps_axis = keeps;
    res.out_length = len;
    res.status     = st;
    return res;
  endfunction

  function automatic void add_row(tair_pkg::req_t stim, logic pinned, tair_pkg::rsp_t want);
    dir_row_t row;
    row.stim   = stim;
    row.pinned = pinned;
    row.want   = want;
    dir_rows   = {dir_rows, row};
  endfunction

  function automatic void build_table();
    tair_pkg::rsp_t none;
    none = '0;
    add_row(mk_req(tair_pkg::KIND_INDEX, 10, 3, 0, 0, 0, 0, 1), 1,
            pin_rsp(0, 0, tair_pkg::ST_OK));
    add_row(mk_req(tair_pkg::KIND_INDEX, 10, 3, 0, -1, 0, 0, 1), 0, none);
    add_row(mk_req(tair_pkg::KIND_INDEX, 10, 3, 1, 10, 1, 0, 1), 1,
            pin_rsp(0, 0, tair_pkg::ST_RANGE));
    add_row(mk_req(tair_pkg::KIND_INDEX, 10, 3, 1, -11, 0, 0, 1), 1,
            pin_rsp(0, 0, tair_pkg::ST_RANGE));
    add_row(mk_req(tair_pkg::KIND_INDEX, 0, 7, 0, 0, 0, 0, 0), 1,
            pin_rsp(0, 0, tair_pkg::ST_RANGE));
    add_row(mk_req(tair_pkg::KIND_INDEX, 1, 5, 0, -1, 0, 0, 0), 1,
            pin_rsp(0, 0, tair_pkg::ST_OK));
    add_row(mk_req(tair_pkg::KIND_INDEX, SIZE_MAX, IDX_MIN, 0, -1, 0, 0, 0), 0, none);
    add_row(mk_req(tair_pkg::KIND_INDEX, SIZE_MAX, IDX_MAX, 0, IDX_MAX, 0, 0, 0), 1,
            pin_rsp(0, 0, tair_pkg::ST_RANGE));
    add_row(mk_req(tair_pkg::KIND_INDEX, SIZE_MAX, IDX_MAX, 0, IDX_MIN, 0, 0, 0), 1,
            pin_rsp(0, 0, tair_pkg::ST_RANGE));
    add_row(mk_req(tair_pkg::KIND_SLICE, 10, 4, 1, 2, 1, 8, 0), 1,
            pin_rsp(0, 0, tair_pkg::ST_ZERO_STEP));
    add_row(mk_req(tair_pkg::KIND_SLICE, 10, 4, 0, 0, 0, 0, IDX_MIN), 1,
            pin_rsp(0, 0, tair_pkg::ST_BIG_STEP));
    add_row(mk_req(tair_pkg::KIND_SLICE, 10, 4, 0, 0, 0, 0, 1), 0, none);
    add_row(mk_req(tair_pkg::KIND_SLICE, 10, 4, 0, 0, 0, 0, -1), 0, none);
    add_row(mk_req(tair_pkg::KIND_SLICE, 10, 4, 1, 5, 1, 2, 1), 0, none);
    add_row(mk_req(tair_pkg::KIND_SLICE, 10, -6, 1, -3, 1, -1, 1), 0, none);
    add_row(mk_req(tair_pkg::KIND_SLICE, 10, 3, 1, 100, 1, -100, -2), 0, none);
    add_row(mk_req(tair_pkg::KIND_SLICE, 0, 3, 0, 0, 0, 0, 1), 0, none);
    add_row(mk_req(tair_pkg::KIND_SLICE, SIZE_MAX, IDX_MAX, 0, 0, 0, 0, IDX_MAX), 0, none);
    add_row(mk_req(tair_pkg::KIND_SLICE, SIZE_MAX, IDX_MIN, 0, 0, 0, 0, IDX_MIN + 1), 0,
            none);
    add_row(mk_req(tair_pkg::KIND_SLICE, 7, 2, 1, IDX_MIN, 1, IDX_MAX, 3), 0, none);
    add_row(mk_req(tair_pkg::KIND_SLICE, SIZE_MAX, -1, 1, IDX_MAX, 1, IDX_MIN, -1), 0,
            none);
    add_row(mk_req(tair_pkg::KIND_NEWAXIS, 10, 4, 0, 0, 0, 0, 0), 1,
            pin_rsp(1, 1, tair_pkg::ST_OK));
    add_row(mk_req(tair_pkg::KIND_NEWAXIS, SIZE_MAX, IDX_MIN, 1, IDX_MIN, 1, IDX_MAX, 0), 1,
            pin_rsp(1, 1, tair_pkg::ST_OK));
    add_row(mk_req(KIND_UNUSED, SIZE_MAX, IDX_MAX, 1, -1, 1, -1, -1), 1,
            pin_rsp(0, 0, tair_pkg::ST_OK));
  endfunction

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 3))
      0: return IDX_MIN;
      1: return IDX_MAX;
      2: return '1;
      default: return '0;
    endcase
  endfunction

  function automatic logic [31:0] near_edge(longint size);
    longint off, v;
    off = longint'($urandom_range(0, 12)) - 6;
    case ($urandom_range(0, 3))
      0: v = off - size;
      1: v = size + off;
      2: v = off;
      default: begin
        v = longint'($urandom_range(0, size));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v[31:0];
  endfunction

  function automatic logic [31:0] pick_index(longint size);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return extreme_word();
      default: return near_edge(size);
    endcase
  endfunction

  function automatic tair_pkg::req_t random_component();
    tair_pkg::req_t r;
    longint         sz, v;
    int             pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.req_type = tair_pkg::KIND_INDEX;
    else if (pick < 80) r.req_type = tair_pkg::KIND_SLICE;
    else if (pick < 92) r.req_type = tair_pkg::KIND_NEWAXIS;
    else r.req_type = KIND_UNUSED;
    case ($urandom_range(0, 9))
      0: sz = 0;
      1: sz = longint'($urandom) & 64'h7fff_ffff;
      2: sz = longint'(SIZE_MAX);
      default: sz = $urandom_range(1, 40);
    endcase
    r.axis_size = sz[30:0];
    case ($urandom_range(0, 7))
      0: r.axis_stride = extreme_word();
      1: r.axis_stride = $urandom;
      default: begin
        v = longint'($urandom_range(0, 16)) - 8;
        r.axis_stride = v[31:0];
      end
    endcase
    r.has_start   = ($urandom_range(0, 9) < 7);
    r.has_stop    = ($urandom_range(0, 9) < 7);
    r.index_start = pick_index(sz);
    r.index_stop  = pick_index(sz);
    case ($urandom_range(0, 19))
      0: r.slice_step = '0;
      1: r.slice_step = IDX_MIN;
      2: r.slice_step = $urandom;
      3: r.slice_step = IDX_MAX;
      4: r.slice_step = IDX_MIN + 1;
      default: begin
        v = $urandom_range(1, 6);
        if ($urandom_range(0, 1) == 1) v = -v;
        r.slice_step = v[31:0];
      end
    endcase
    return r;
  endfunction

  task automatic offer(tair_pkg::req_t item, logic pinned, tair_pkg::rsp_t want);
    tair_pkg::rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted  = pinned ? want : resolve_component(item);
    resolved_q = {resolved_q, predicted};
    components_sent++;
  endtask

  // Receiver: pace rsp_ready and check each accepted result in order.
  always @(posedge clk) begin : rsp_side
    tair_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        resolutions_checked++;
        if (resolved_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: keep=%0d len=%0d stride=%0d delta=%0d st=%0d",
                     rsp.keeps_axis, rsp.out_length, $signed(rsp.out_stride),
                     $signed(rsp.offset_delta), rsp.status);
        end else begin
          want = resolved_q.pop_front();
          if (rsp.keeps_axis !== want.keeps_axis || rsp.out_length !== want.out_length ||
              rsp.out_stride !== want.out_stride ||
              rsp.offset_delta !== want.offset_delta || rsp.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d", resolutions_checked);
              $display("  expected keep=%0d len=%0d stride=%0d delta=%0d st=%0d",
                       want.keeps_axis, want.out_length, $signed(want.out_stride),
                       $signed(want.offset_delta), want.status);
              $display("  actual   keep=%0d len=%0d stride=%0d delta=%0d st=%0d",
                       rsp.keeps_axis, rsp.out_length, $signed(rsp.out_stride),
                       $signed(rsp.offset_delta), rsp.status);
            end
          end
        end
      end
      if (hold_left != 0) begin
        rsp_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (phase == 2 && !hold_done) begin
        rsp_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_ready) input_stalls++;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : feed
    int quota;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    build_table();
    send_idle_pct = 23;
    recv_idle_pct = 75;
    foreach (dir_rows[i]) offer(dir_rows[i].stim, dir_rows[i].pinned, dir_rows[i].want);
    for (int p = 0; p < 3; p++) begin
      phase         = p;
      send_idle_pct = (p == 0) ? 23 : (p == 1) ? 75 : 0;
      recv_idle_pct = (p == 0) ? 75 : (p == 1) ? 23 : 0;
      quota         = (p == 2) ? RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3) : RANDOM_ITEMS / 3;
      for (int n = 0; n < quota; n++) offer(random_component(), 1'b0, '0);
    end
    req_valid <= 1'b0;
    while (resolved_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += resolved_q.size();
    $display("Resolved %0d components (%0d table rows, rest random) over three pacing phases",
             components_sent, dir_rows.size());
    $display("Checked %0d results, %0d input stall cycles, %0d mismatches",
             resolutions_checked, input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/tair_pkg.sv
sv/tair_front.sv
sv/tair_cell.sv
sv/tair_out.sv
sv/tensor_axis_index_resolver.sv
sv/tair_checker.sv
tb/tensor_axis_index_resolver_tb.sv
